@@ hw/rtl/bis_pkg.sv @@
package bis_pkg;

  // Field widths of the item ports and of the configuration register.
  localparam int unsigned ELEM_W = 10;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POP_W  = 11;

  // Default geometry of the bitmap.
  localparam int unsigned UNIVERSE_DEF  = 1024;
  localparam int unsigned WORD_BITS_DEF = 64;

  // Operation codes. Codes above OP_QUERY act as a query.
  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ELEM_W-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic              was_member;
    logic              next_found;
    logic [ELEM_W-1:0] next_member;
    logic              first_found;
    logic [ELEM_W-1:0] first_member;
    logic [POP_W-1:0]  population;
    logic              range_error;
  } out_item_t;

endpackage

@@ hw/rtl/bitmap_integer_set.sv @@
// Bitmap integer set with find-next and find-first.
//
// The input channel takes one item per operation (op and element) with valid
// and stall; the output channel returns one result item per input item, in
// order, with the same handshake. The configuration channel (valid/ready)
// writes max_element, the greatest element in use; a write empties the set.
// Configuration is written only while idle, and a pending write holds off items.
//
// Every item makes one pass over the bitmap memory, one word per cycle
// through its single read port. The word that holds the element is modified
// and written back on the fly (fill and clear rewrite every word), and the
// same pass finds the lowest member and the next member above the element.
// An item is read word by word (16 words with the default 1024 elements in
// 64-bit words), and its result goes to the output register once the last
// word is processed. The input stalls meanwhile, so a new item is taken only
// after the result of the last one is registered.
//
// Reset empties the set at once through per-word valid bits and sets max_element
// to its greatest value. A stalled result holds in the output register while the
// next item is taken and scanned; that item then waits for the register.
module bitmap_integer_set #(
  parameter int unsigned UNIVERSE  = bis_pkg::UNIVERSE_DEF,
  parameter int unsigned WORD_BITS = bis_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bis_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bis_pkg::out_item_t          out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bis_pkg::ELEM_W-1:0]  cfg_data_i
);
  import bis_pkg::*;

  // Elements never exceed the element field, so only that much of the
  // universe is ever stored.
  localparam int unsigned ELEM_SPAN = 1 << ELEM_W;
  localparam int unsigned USED      = (UNIVERSE < ELEM_SPAN) ? UNIVERSE : ELEM_SPAN;
  localparam int unsigned NUM_WORDS = (USED + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned BASE_W    = ELEM_W + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_WORDS - 1);
  localparam logic [ELEM_W-1:0] LIM_CAP   = ELEM_W'(USED - 1);
  localparam logic [BASE_W-1:0] WORD_STEP = BASE_W'(WORD_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Lowest set bit of a word.
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  logic [1:0]          state_q;
  logic [ELEM_W-1:0]   max_q;
  logic [POP_W-1:0]    count_q;
  logic [NUM_WORDS-1:0] row_vld_q;

  // Item context, captured at acceptance.
  logic [OP_W-1:0]     op_q;
  logic [ELEM_W-1:0]   el_q;
  logic [ELEM_W-1:0]   lim_q;
  logic                bad_q;

  // Read side of the pass.
  logic                rd_active_q;
  logic [ADDR_W-1:0]   rd_ptr_q;
  logic [BASE_W-1:0]   rd_base_q;

  // Word under processing, in the cycle after its read.
  logic                proc_vld_q;
  logic                proc_last_q;
  logic [ADDR_W-1:0]   proc_addr_q;
  logic [BASE_W-1:0]   proc_base_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                rd_row_vld_q;

  // Results gathered over the pass.
  logic                passed_q;
  logic                was_q;
  logic                ff_q;
  logic [ELEM_W-1:0]   fm_q;
  logic                nf_q;
  logic [ELEM_W-1:0]   nm_q;

  logic                out_valid_q;
  out_item_t           out_q;

  logic [WORD_BITS-1:0] mem_q [NUM_WORDS];

  logic                in_acc;
  logic                cfg_acc;
  logic                out_free;
  logic                rd_en;
  logic [ELEM_W-1:0]   lim_now;
  logic                bad_now;

  logic [BASE_W-1:0]   off_diff;
  logic                hit;
  logic [BIT_W-1:0]    off;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] bit_sel;
  logic [WORD_BITS-1:0] fill_mask;
  logic [WORD_BITS-1:0] gt_mask;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] next_bits;
  logic [BASE_W-1:0]   span;
  logic                fill_any;
  logic                wr_en;
  logic                cur_bit;

  // A configuration write takes precedence over a new item.
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign rd_en       = (state_q == ST_SCAN) && rd_active_q;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The limit in force is the smaller of the register and the stored universe.
  assign lim_now = (max_q > LIM_CAP) ? LIM_CAP : max_q;
  assign bad_now = in_item_i.element > lim_now;

  // Word processing: locate the element in this word, build the new word
  // and the mask of bits strictly above the element.
  always_comb begin
    off_diff = {1'b0, el_q} - proc_base_q;
    hit      = proc_vld_q && ({1'b0, el_q} >= proc_base_q) && (off_diff < WORD_STEP);
    off      = off_diff[BIT_W-1:0];
    cur_word = rd_data_q & {WORD_BITS{rd_row_vld_q}};
    bit_sel  = {{(WORD_BITS - 1){1'b0}}, 1'b1} << off;
    cur_bit  = |(cur_word & bit_sel);

    fill_any = {1'b0, lim_q} >= proc_base_q;
    span     = {1'b0, lim_q} - proc_base_q;
    for (int i = 0; i < WORD_BITS; i++) begin
      fill_mask[i] = fill_any && (BASE_W'(i) <= span);
      gt_mask[i]   = !bad_q && (passed_q || (hit && (BIT_W'(i) > off)));
    end

    new_word = cur_word;
    wr_en    = 1'b0;
    if (proc_vld_q && !bad_q) begin
      case (op_q)
        OP_ADD: begin
          if (hit) begin
            new_word = cur_word | bit_sel;
            wr_en    = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            new_word = cur_word & ~bit_sel;
            wr_en    = 1'b1;
          end
        end
        OP_FILL: begin
          new_word = fill_mask;
          wr_en    = 1'b1;
        end
        OP_CLEAR: begin
          new_word = '0;
          wr_en    = 1'b1;
        end
        default: begin
          new_word = cur_word;
        end
      endcase
    end
    next_bits = new_word & gt_mask;
  end

  // Bitmap memory: one write and one registered read per cycle. The word
  // written back in a cycle is never the one read in that cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[proc_addr_q] <= new_word;
    end
    if (rd_en) begin
      rd_data_q    <= mem_q[rd_ptr_q];
      rd_row_vld_q <= row_vld_q[rd_ptr_q];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_q       <= '1;
      count_q     <= '0;
      row_vld_q   <= '0;
      rd_active_q <= 1'b0;
      proc_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      proc_vld_q <= rd_en;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_acc) begin
        // Resizing empties the set.
        max_q     <= cfg_data_i;
        count_q   <= '0;
        row_vld_q <= '0;
      end

      if (wr_en) begin
        row_vld_q[proc_addr_q] <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q     <= ST_SCAN;
            rd_active_q <= 1'b1;
            if (!bad_now) begin
              if (in_item_i.op == OP_FILL) begin
                count_q <= POP_W'(lim_now) + POP_W'(1);
              end else if (in_item_i.op == OP_CLEAR) begin
                count_q <= '0;
              end
            end
          end
        end
        ST_SCAN: begin
          if (rd_en && (rd_ptr_q == LAST_ADDR)) begin
            rd_active_q <= 1'b0;
          end
          if (hit && !bad_q) begin
            if ((op_q == OP_ADD) && !cur_bit) begin
              count_q <= count_q + POP_W'(1);
            end else if ((op_q == OP_REMOVE) && cur_bit) begin
              count_q <= count_q - POP_W'(1);
            end
          end
          if (proc_vld_q && proc_last_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Item context, pass pointers and gathered results.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= in_item_i.op;
      el_q      <= in_item_i.element;
      lim_q     <= lim_now;
      bad_q     <= bad_now;
      rd_ptr_q  <= '0;
      rd_base_q <= '0;
      passed_q  <= 1'b0;
      was_q     <= 1'b0;
      ff_q      <= 1'b0;
      fm_q      <= '0;
      nf_q      <= 1'b0;
      nm_q      <= '0;
    end else begin
      if (rd_en) begin
        rd_ptr_q  <= rd_ptr_q + ADDR_W'(1);
        rd_base_q <= rd_base_q + WORD_STEP;
      end
      if (hit) begin
        passed_q <= 1'b1;
        was_q    <= !bad_q && cur_bit;
      end
      if (proc_vld_q && !ff_q && (new_word != '0)) begin
        ff_q <= 1'b1;
        fm_q <= ELEM_W'(proc_base_q + BASE_W'(lowest_bit(new_word)));
      end
      if (proc_vld_q && !nf_q && (next_bits != '0)) begin
        nf_q <= 1'b1;
        nm_q <= ELEM_W'(proc_base_q + BASE_W'(lowest_bit(next_bits)));
      end
    end
    proc_addr_q <= rd_ptr_q;
    proc_base_q <= rd_base_q;
    proc_last_q <= (rd_ptr_q == LAST_ADDR);

    if ((state_q == ST_DONE) && out_free) begin
      out_q.was_member   <= was_q;
      out_q.next_found   <= nf_q;
      out_q.next_member  <= nm_q;
      out_q.first_found  <= ff_q;
      out_q.first_member <= fm_q;
      out_q.population   <= count_q;
      out_q.range_error  <= bad_q;
    end
  end

  // A result reports a non-empty set exactly when its population is nonzero.
  a_first_matches_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.first_found == (out_item_o.population != '0)))
    else $error("first_found disagrees with population");

  // An ignored element reports no membership and no next member.
  a_range_error_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.range_error) |->
      (!out_item_o.was_member && !out_item_o.next_found))
    else $error("range error result carries membership data");

  // A next member is a member, so it cannot lie below the lowest member.
  a_next_above_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.next_found) |->
      (out_item_o.first_found && (out_item_o.next_member >= out_item_o.first_member)))
    else $error("next member below first member");

  // The member count never exceeds the stored universe.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= POP_W'(USED))
    else $error("member count out of range");

endmodule
